// File: rtl/core/cam_pkg.sv
// Shared types and constants for the cross-arm mask filter.
package cam_pkg;

    // Field widths fixed by the block's interface
    localparam int ROW_BITS   = 10;
    localparam int COL_BITS   = 12;
    localparam int CFG_BITS   = 11;
    localparam int ARM_BITS   = 6;
    localparam int INROW_BITS = 11;
    localparam int MAX_HEIGHT = 1024;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;

    // Configuration register indexes
    localparam logic [1:0] REG_ARM_LENGTH   = 2'd0;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

    // Request types
    localparam logic REQ_PIXEL = 1'b0;

    // Effective (clamped) frame settings
    typedef struct packed {
        logic [ARM_BITS-1:0] arm;
        logic [CFG_BITS-1:0] width;
        logic [CFG_BITS-1:0] height;
    } frame_cfg_t;

    // One classified request handed from front to back
    typedef struct packed {
        logic                  wr;
        logic                  val;
        logic                  ev;
        logic                  last;
        logic [ROW_BITS-1:0]   in_row;
        logic [COL_BITS-1:0]   col;
        logic [ROW_BITS-1:0]   ev_row;
    } entry_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_STORE,
        B_SCAN,
        B_SETTLE,
        B_WB
    } back_state_t;

endpackage

// File: rtl/core/cam_queue.sv
// Small FIFO of classified requests between front and back.
module cam_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cam_pkg::entry_t push_data,
    input  logic            pop,
    output cam_pkg::entry_t head,
    output logic            full,
    output logic            empty
);

    cam_pkg::entry_t                   slots_reg [cam_pkg::QUEUE_DEPTH];
    logic [cam_pkg::QPTR_BITS-1:0]     wp_reg;
    logic [cam_pkg::QPTR_BITS-1:0]     rp_reg;
    logic [cam_pkg::QPTR_BITS:0]       cnt_reg;

    assign full  = (cnt_reg == (cam_pkg::QPTR_BITS+1)'(cam_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slots_reg[rp_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Store requests
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wp_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/cam_front.sv
// Front end: accepts requests, tracks the input position and classifies each request.
module cam_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                restart,
    input  cam_pkg::frame_cfg_t fcfg,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                req_type,
    input  logic                pixel_on,
    output logic                push,
    output cam_pkg::entry_t     push_data,
    input  logic                q_full
);

    logic [cam_pkg::INROW_BITS-1:0] in_row_reg;
    logic [cam_pkg::INROW_BITS-1:0] in_row_next;
    logic [cam_pkg::COL_BITS-1:0]   in_col_reg;
    logic [cam_pkg::COL_BITS-1:0]   in_col_next;
    logic [cam_pkg::INROW_BITS-1:0] lag_rows;
    logic                           is_last;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;
    assign lag_rows = cam_pkg::INROW_BITS'(fcfg.arm - 1'b1);

    // Classify the request at the current input position
    always_comb
    begin
        is_last = (in_row_reg == cam_pkg::INROW_BITS'(fcfg.height - 1'b1) + lag_rows)
               && (in_col_reg == cam_pkg::COL_BITS'(fcfg.width - 1'b1));
        push_data.wr     = (in_row_reg < fcfg.height);
        push_data.val    = (req_type == cam_pkg::REQ_PIXEL) ? pixel_on : 1'b0;
        push_data.ev     = (in_row_reg >= lag_rows);
        push_data.last   = is_last;
        push_data.in_row = cam_pkg::ROW_BITS'(in_row_reg);
        push_data.col    = in_col_reg;
        push_data.ev_row = cam_pkg::ROW_BITS'(in_row_reg - lag_rows);
    end

    // Advance the raster position, wrap at frame end
    always_comb
    begin
        in_row_next = in_row_reg;
        in_col_next = in_col_reg;
        if (restart)
        begin
            in_row_next = '0;
            in_col_next = '0;
        end
        else if (push)
        begin
            if (is_last)
            begin
                in_row_next = '0;
                in_col_next = '0;
            end
            else if (cam_pkg::COL_BITS'(in_col_reg + 1'b1)
                     == cam_pkg::COL_BITS'(fcfg.width))
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + 1'b1;
            end
            else
            begin
                in_col_next = in_col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg <= '0;
            in_col_reg <= '0;
        end
        else
        begin
            in_row_reg <= in_row_next;
            in_col_reg <= in_col_next;
        end
    end

endmodule

// File: rtl/core/cam_back.sv
// Back end: row store, four-arm scan one distance at a time, and result register.
module cam_back
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_ARM   = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cam_pkg::frame_cfg_t fcfg,
    input  cam_pkg::entry_t     head,
    input  logic                q_empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                keep_pixel,
    output logic [9:0]          pixel_row,
    output logic [9:0]          pixel_col,
    output logic                last_of_frame
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int SW    = $clog2(2 * MAX_ARM);
    localparam int DW    = $clog2(MAX_ARM);
    localparam int AW    = SW + CW;
    localparam int DEPTH = 2 ** AW;

    logic                mem [DEPTH];

    cam_pkg::back_state_t state_reg;
    cam_pkg::back_state_t state_next;
    cam_pkg::entry_t     cur_reg;
    logic [DW-1:0]       d_reg;
    logic                ph_reg;
    logic                keep_reg;
    logic                vhit_reg;
    logic                pv_reg;
    logic                pph_reg;
    logic                pok0_reg;
    logic                pok1_reg;
    logic                q0_reg;
    logic                q1_reg;
    logic                out_valid_reg;
    logic                keep_o_reg;
    logic [9:0]          row_o_reg;
    logic [9:0]          col_o_reg;
    logic                last_o_reg;

    logic                out_free;
    logic                last_issue;
    logic                mem_we;
    logic [AW-1:0]       waddr;
    logic                wdata;
    logic [AW-1:0]       ra0;
    logic [AW-1:0]       ra1;
    logic                ok0;
    logic                ok1;
    logic                hit;
    logic [cam_pkg::ROW_BITS-1:0] dd_row;
    logic [cam_pkg::COL_BITS-1:0] dd_col;
    logic [cam_pkg::ROW_BITS-1:0] r_up;
    logic [cam_pkg::ROW_BITS-1:0] r_dn;
    logic [cam_pkg::COL_BITS-1:0] c_lt;
    logic [cam_pkg::COL_BITS-1:0] c_rt;

    assign out_free   = !out_valid_reg || !out_stall;
    assign last_issue = ph_reg && (cam_pkg::ARM_BITS'(d_reg) == fcfg.arm - 1'b1);
    assign hit        = (q0_reg && pok0_reg) || (q1_reg && pok1_reg);

    // Arm addresses and frame-edge checks for the current distance
    always_comb
    begin
        dd_row = cam_pkg::ROW_BITS'(d_reg);
        dd_col = cam_pkg::COL_BITS'(d_reg);
        r_up   = cur_reg.ev_row - dd_row;
        r_dn   = cur_reg.ev_row + dd_row;
        c_lt   = cur_reg.col - dd_col;
        c_rt   = cur_reg.col + dd_col;
        if (ph_reg)
        begin
            ra0 = {cur_reg.ev_row[SW-1:0], c_lt[CW-1:0]};
            ra1 = {cur_reg.ev_row[SW-1:0], c_rt[CW-1:0]};
            ok0 = (cur_reg.col >= dd_col);
            ok1 = ((cam_pkg::COL_BITS+1)'(cur_reg.col) + (cam_pkg::COL_BITS+1)'(dd_col))
                  < (cam_pkg::COL_BITS+1)'(fcfg.width);
        end
        else
        begin
            ra0 = {r_up[SW-1:0], cur_reg.col[CW-1:0]};
            ra1 = {r_dn[SW-1:0], cur_reg.col[CW-1:0]};
            ok0 = (cur_reg.ev_row >= dd_row);
            ok1 = (cam_pkg::CFG_BITS'(cur_reg.ev_row) + cam_pkg::CFG_BITS'(dd_row))
                  < fcfg.height;
        end
    end

    // Next state, pop and store write
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        mem_we     = 1'b0;
        waddr      = {cur_reg.in_row[SW-1:0], cur_reg.col[CW-1:0]};
        wdata      = cur_reg.val;
        case (state_reg)
            cam_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    state_next = cam_pkg::B_STORE;
                end
            end
            cam_pkg::B_STORE:
            begin
                mem_we     = cur_reg.wr;
                state_next = cur_reg.ev ? cam_pkg::B_SCAN : cam_pkg::B_IDLE;
            end
            cam_pkg::B_SCAN:
            begin
                if (last_issue)
                begin
                    state_next = cam_pkg::B_SETTLE;
                end
            end
            cam_pkg::B_SETTLE:
            begin
                state_next = cam_pkg::B_WB;
            end
            cam_pkg::B_WB:
            begin
                waddr = {cur_reg.ev_row[SW-1:0], cur_reg.col[CW-1:0]};
                wdata = keep_reg;
                if (out_free)
                begin
                    mem_we     = 1'b1;
                    state_next = cam_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = cam_pkg::B_IDLE;
            end
        endcase
    end

    // State, scan counters and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cam_pkg::B_IDLE;
            d_reg         <= '0;
            ph_reg        <= 1'b0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pv_reg    <= (state_reg == cam_pkg::B_SCAN);
            if (state_reg == cam_pkg::B_STORE)
            begin
                d_reg  <= '0;
                ph_reg <= 1'b0;
            end
            else if (state_reg == cam_pkg::B_SCAN)
            begin
                ph_reg <= !ph_reg;
                if (ph_reg)
                begin
                    d_reg <= d_reg + 1'b1;
                end
            end
            if (state_reg == cam_pkg::B_WB && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: current request, arm results, result fields
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        pph_reg  <= ph_reg;
        pok0_reg <= ok0;
        pok1_reg <= ok1;
        if (state_reg == cam_pkg::B_STORE)
        begin
            keep_reg <= 1'b1;
        end
        else if (pv_reg)
        begin
            if (!pph_reg)
            begin
                vhit_reg <= hit;
            end
            else
            begin
                keep_reg <= keep_reg && (vhit_reg || hit);
            end
        end
        if (state_reg == cam_pkg::B_WB && out_free)
        begin
            keep_o_reg <= keep_reg;
            row_o_reg  <= cur_reg.ev_row;
            col_o_reg  <= cur_reg.col[9:0];
            last_o_reg <= cur_reg.last;
        end
    end

    // Row store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        q0_reg <= mem[ra0];
        q1_reg <= mem[ra1];
    end

    assign out_valid     = out_valid_reg;
    assign keep_pixel    = keep_o_reg;
    assign pixel_row     = row_o_reg;
    assign pixel_col     = col_o_reg;
    assign last_of_frame = last_o_reg;

endmodule

// File: rtl/core/cross_arm_mask_filter.sv
// Cross-arm mask filter top level: configuration registers, front, queue and back.
//
// Usage: mask pixels enter in raster order on the input channel (in_valid,
// in_stall, req_type, pixel_on); pad requests follow the frame to drain it.
// Filtered pixels leave on the output channel (out_valid, out_stall) with
// their row, column and an end-of-frame flag. A request is taken when valid
// is high and stall is low.
// Results lag the input by arm_length-1 rows; requests in that lag give no
// result. The back end scans each request that yields a result one arm
// distance at a time (two reads per cycle on the row store's two read
// ports, vertical then horizontal arms) and only stores one that does not.
// A four-deep request queue lets the input run ahead of the back end; the
// output register lets the back end store and scan its next request while a
// result is held under out_stall.
// Reset clears the position counters, queue and output valid and loads the
// default settings (arm 10, 640 x 480). Register writes take effect at once
// and restart the frame; write them only while the block is idle.
module cross_arm_mask_filter
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_ARM   = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic        pixel_on,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        keep_pixel,
    output logic [9:0]  pixel_row,
    output logic [9:0]  pixel_col,
    output logic        last_of_frame
);

    logic [4:0]                   arm_reg;
    logic [cam_pkg::CFG_BITS-1:0] width_reg;
    logic [cam_pkg::CFG_BITS-1:0] height_reg;
    logic                         restart;
    cam_pkg::frame_cfg_t          fcfg;
    cam_pkg::entry_t              push_data;
    cam_pkg::entry_t              head;
    logic                         push;
    logic                         pop;
    logic                         q_full;
    logic                         q_empty;

    assign restart = cfg_we && (cfg_index == cam_pkg::REG_ARM_LENGTH
                             || cfg_index == cam_pkg::REG_FRAME_WIDTH
                             || cfg_index == cam_pkg::REG_FRAME_HEIGHT);

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arm_reg    <= 5'd10;
            width_reg  <= 11'd640;
            height_reg <= 11'd480;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cam_pkg::REG_ARM_LENGTH:   arm_reg    <= cfg_data[4:0];
                cam_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                cam_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Clamp settings to their supported ranges
    always_comb
    begin
        if (arm_reg == '0)
            fcfg.arm = cam_pkg::ARM_BITS'(1);
        else if (32'(arm_reg) > MAX_ARM)
            fcfg.arm = cam_pkg::ARM_BITS'(MAX_ARM);
        else
            fcfg.arm = cam_pkg::ARM_BITS'(arm_reg);
        if (width_reg == '0)
            fcfg.width = cam_pkg::CFG_BITS'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            fcfg.width = cam_pkg::CFG_BITS'(MAX_WIDTH);
        else
            fcfg.width = width_reg;
        if (height_reg == '0)
            fcfg.height = cam_pkg::CFG_BITS'(1);
        else if (32'(height_reg) > cam_pkg::MAX_HEIGHT)
            fcfg.height = cam_pkg::CFG_BITS'(cam_pkg::MAX_HEIGHT);
        else
            fcfg.height = height_reg;
    end

    cam_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (restart),
        .fcfg      (fcfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .pixel_on  (pixel_on),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    cam_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    cam_back
    #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ARM   (MAX_ARM)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .fcfg          (fcfg),
        .head          (head),
        .q_empty       (q_empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .keep_pixel    (keep_pixel),
        .pixel_row     (pixel_row),
        .pixel_col     (pixel_col),
        .last_of_frame (last_of_frame)
    );

endmodule

// File: rtl/core/cam_checker.sv
// Port-level checks for the cross-arm mask filter, bound to the top level.
module cam_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       keep_pixel,
    input logic [9:0] pixel_row,
    input logic [9:0] pixel_col,
    input logic       last_of_frame
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_row) && $stable(pixel_col))
        else $error("stalled result changed");

    // Hold the kept and end-of-frame flags of a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(keep_pixel) && $stable(last_of_frame))
        else $error("stalled result flags changed");

    // Keep results off during reset
    assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind cross_arm_mask_filter cam_checker u_cam_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .keep_pixel    (keep_pixel),
    .pixel_row     (pixel_row),
    .pixel_col     (pixel_col),
    .last_of_frame (last_of_frame)
);

// File: tb/sv/cross_arm_mask_filter_test.sv
// Self-checking testbench for the cross-arm mask filter.
module cross_arm_mask_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic REQ_PAD       = 1'b1;
    localparam int   STORE_ROWS    = 32;
    localparam int   STORE_COLS    = 1024;
    localparam int   ARM_MAX       = 16;
    localparam int   DRAIN_CYCLES  = 200;
    localparam int   STUCK_LIMIT   = 20000;
    localparam int   RANDOM_ITEMS  = 550;

    typedef struct packed {
        logic       keep;
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
    } filtered_px_t;

    // One directed row: either a register write or a request
    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [10:0] data;
        logic        rt;
        logic        pix;
        bit          chk;
        bit          keep;
    } step_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic        pixel_on;
    logic        out_valid;
    logic        out_stall;
    logic        keep_pixel;
    logic [9:0]  pixel_row;
    logic [9:0]  pixel_col;
    logic        last_of_frame;

    // Filter state mirrored in the testbench
    bit           mask_rows [STORE_ROWS][STORE_COLS];
    int unsigned  in_pos;
    int unsigned  next_row;
    int unsigned  next_col;
    logic [4:0]   arm_reg;
    logic [10:0]  width_reg;
    logic [10:0]  height_reg;

    filtered_px_t pending_px[$];
    step_row_t    steps[$];
    int           mismatches;
    int           send_gap;
    int           recv_gap;
    int           quiet_cycles;

    cross_arm_mask_filter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .pixel_on      (pixel_on),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .keep_pixel    (keep_pixel),
        .pixel_row     (pixel_row),
        .pixel_col     (pixel_col),
        .last_of_frame (last_of_frame)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int clamp(int v, int lo, int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic bit mask_at(int r, int c, int w, int h);
        if (r < 0 || c < 0 || r >= h || c >= w)
            return 1'b0;
        return mask_rows[r % STORE_ROWS][c % STORE_COLS];
    endfunction

    function automatic void restart_frame();
        in_pos   = 0;
        next_row = 0;
        next_col = 0;
    endfunction

    function automatic void apply_reg(logic [1:0] idx, logic [10:0] data);
        case (idx)
            cam_pkg::REG_ARM_LENGTH:   arm_reg    = data[4:0];
            cam_pkg::REG_FRAME_WIDTH:  width_reg  = data;
            cam_pkg::REG_FRAME_HEIGHT: height_reg = data;
            default: return;
        endcase
        restart_frame();
    endfunction

    // Append a register write to the directed table
    function automatic void add_cfg_row(logic [1:0] idx, logic [10:0] data);
        step_row_t row;
        row = '{1'b1, idx, data, cam_pkg::REQ_PIXEL, 1'b0, 1'b0, 1'b0};
        steps.insert(steps.size(), row);
    endfunction

    // Append a request to the directed table
    function automatic void add_req_row(logic rt, logic pix, bit chk, bit keep);
        step_row_t row;
        row = '{1'b0, cam_pkg::REG_ARM_LENGTH, 11'd0, rt, pix, chk, keep};
        steps.insert(steps.size(), row);
    endfunction

    // Store the request, then filter the pixel that is due; returns 1 on a result
    function automatic bit filter_request(logic rt, logic pix, output bit kept);
        int          arm;
        int          w;
        int          h;
        int unsigned p;
        int          r;
        int          c;
        bit          keep;
        bit          last;
        filtered_px_t px;
        arm  = clamp(arm_reg, 1, ARM_MAX);
        w    = clamp(width_reg, 1, 1024);
        h    = clamp(height_reg, 1, 1024);
        p    = in_pos;
        kept = 1'b0;
        if (p < w * h)
            mask_rows[(p / w) % STORE_ROWS][p % w] = (rt == cam_pkg::REQ_PIXEL) ? pix : 1'b0;
        in_pos = p + 1;
        if (p < (arm - 1) * w)
            return 1'b0;
        r    = next_row;
        c    = next_col;
        keep = 1'b1;
        for (int d = 0; d < arm; d++)
        begin
            if (!(mask_at(r + d, c, w, h) | mask_at(r - d, c, w, h) |
                  mask_at(r, c + d, w, h) | mask_at(r, c - d, w, h)))
            begin
                keep = 1'b0;
                break;
            end
        end
        mask_rows[r % STORE_ROWS][c % STORE_COLS] = keep;
        last = (r + 1 >= h) && (c + 1 >= w);
        px = '{keep, r[9:0], c[9:0], last};
        pending_px.insert(pending_px.size(), px);
        if (last)
            restart_frame();
        else
        begin
            next_col++;
            if (next_col >= w)
            begin
                next_col = 0;
                next_row++;
            end
        end
        kept = keep;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Offer one request, with random idle cycles first
    task automatic send_request(logic rt, logic pix, output bit had_px, output bit kept);
        while ($urandom_range(99) < send_gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        pixel_on <= pix;
        do
            @(posedge clk);
        while (in_stall);
        had_px = filter_request(rt, pix, kept);
    endtask

    // Drain outstanding results, then let the back end settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_px.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_reg(idx, data);
    endtask

    // Pick a register value: mostly small sizes, sometimes the extremes
    function automatic logic [10:0] pick_value(logic [1:0] idx);
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return 11'd0;
        if (roll < 14)
            return 11'h7FF;
        if (roll < 18)
            return $urandom_range(2047, 0);
        if (idx == cam_pkg::REG_ARM_LENGTH)
            return (roll < 24) ? 11'd16 : $urandom_range(5, 1);
        if (idx == cam_pkg::REG_FRAME_WIDTH)
            return (roll < 22) ? 11'd1024 : $urandom_range(12, 1);
        return (roll < 22) ? 11'd1024 : $urandom_range(8, 1);
    endfunction

    // Check each result taken from the block, and stall at random
    always @(posedge clk or negedge rst_n)
    begin
        filtered_px_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_px.size() == 0)
                    report_mismatch("unexpected result at row", pixel_row, -1);
                else
                begin
                    want = pending_px.pop_front();
                    if (keep_pixel !== want.keep)
                        report_mismatch("keep_pixel", keep_pixel, want.keep);
                    if (pixel_row !== want.row)
                        report_mismatch("pixel_row", pixel_row, want.row);
                    if (pixel_col !== want.col)
                        report_mismatch("pixel_col", pixel_col, want.col);
                    if (last_of_frame !== want.last)
                        report_mismatch("last_of_frame", last_of_frame, want.last);
                end
            end
            out_stall <= ($urandom_range(99) < recv_gap);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STUCK_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        bit          had_px;
        bit          kept;
        int          sent;
        int          arm;
        int          w;
        int          h;
        int          n;
        int          on_pct;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = cam_pkg::REG_ARM_LENGTH;
        cfg_data     = '0;
        in_valid     = 1'b0;
        req_type     = cam_pkg::REQ_PIXEL;
        pixel_on     = 1'b0;
        quiet_cycles = 0;
        mismatches   = 0;
        send_gap     = 11;
        recv_gap     = 57;
        arm_reg      = 5'd10;
        width_reg    = 11'd640;
        height_reg   = 11'd480;
        restart_frame();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Arm 0 clamps to 1: a pixel survives only if it is set itself
        add_cfg_row(cam_pkg::REG_ARM_LENGTH,   11'd0);
        add_cfg_row(cam_pkg::REG_FRAME_WIDTH,  11'd3);
        add_cfg_row(cam_pkg::REG_FRAME_HEIGHT, 11'd1);
        add_req_row(cam_pkg::REQ_PIXEL, 1, 1, 1);
        add_req_row(cam_pkg::REQ_PIXEL, 0, 1, 0);
        add_req_row(REQ_PAD,            1, 1, 0);
        // Arm 2 on a 2 x 2 frame; pad inside frame, mask pixels past frame end
        add_cfg_row(cam_pkg::REG_ARM_LENGTH,   11'd2);
        add_cfg_row(cam_pkg::REG_FRAME_WIDTH,  11'd2);
        add_cfg_row(cam_pkg::REG_FRAME_HEIGHT, 11'd2);
        add_req_row(cam_pkg::REQ_PIXEL, 1, 0, 0);
        add_req_row(cam_pkg::REQ_PIXEL, 1, 0, 0);
        add_req_row(cam_pkg::REQ_PIXEL, 1, 0, 0);
        add_req_row(REQ_PAD,            0, 0, 0);
        add_req_row(cam_pkg::REQ_PIXEL, 1, 0, 0);
        add_req_row(cam_pkg::REQ_PIXEL, 0, 0, 0);
        // Arm 31 clamps to 16; oversize width and height clamp to 1024
        add_cfg_row(cam_pkg::REG_ARM_LENGTH,   11'h7FF);
        add_cfg_row(cam_pkg::REG_FRAME_WIDTH,  11'h7FF);
        add_cfg_row(cam_pkg::REG_FRAME_HEIGHT, 11'h7FF);
        add_req_row(cam_pkg::REQ_PIXEL, 1, 0, 0);
        add_req_row(REQ_PAD,            0, 0, 0);

        for (int i = 0; i < steps.size(); i++)
        begin
            if (steps[i].is_cfg)
            begin
                wait_idle();
                write_reg(steps[i].idx, steps[i].data);
                cfg_we <= 1'b0;
            end
            else
            begin
                send_request(steps[i].rt, steps[i].pix, had_px, kept);
                if (steps[i].chk && (!had_px || kept != steps[i].keep))
                    report_mismatch("directed keep", kept, steps[i].keep);
            end
        end

        // Random frames, reconfiguring between some of them
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent == 0 || $urandom_range(99) < 45)
            begin
                wait_idle();
                for (int k = 0; k < 3; k++)
                    if (sent == 0 || $urandom_range(1))
                        write_reg(k[1:0], pick_value(k[1:0]));
                cfg_we <= 1'b0;
            end
            arm    = clamp(arm_reg, 1, ARM_MAX);
            w      = clamp(width_reg, 1, 1024);
            h      = clamp(height_reg, 1, 1024);
            n      = w * h + (arm - 1) * w;
            if (n > 300 || $urandom_range(99) < 12)
                n = $urandom_range(40, 1);
            on_pct = $urandom_range(95, 50);
            for (int i = 0; i < n; i++)
            begin
                if (sent < RANDOM_ITEMS / 3)
                begin
                    send_gap = 11;
                    recv_gap = 57;
                end
                else if (sent < 2 * RANDOM_ITEMS / 3)
                begin
                    send_gap = 57;
                    recv_gap = 11;
                end
                else
                begin
                    send_gap = 0;
                    recv_gap = 0;
                end
                // Pads or pixels past the frame drain it; occasional stray pads inside it are noise
                if (i >= w * h)
                    send_request($urandom_range(1), $urandom_range(1), had_px, kept);
                else if ($urandom_range(99) < 4)
                    send_request(REQ_PAD, $urandom_range(1), had_px, kept);
                else
                    send_request(cam_pkg::REQ_PIXEL, $urandom_range(99) < on_pct,
                                 had_px, kept);
                sent++;
            end
        end

        in_valid <= 1'b0;
        while (pending_px.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// File: sim.f
rtl/core/cam_pkg.sv
rtl/core/cam_queue.sv
rtl/core/cam_front.sv
rtl/core/cam_back.sv
rtl/core/cross_arm_mask_filter.sv
rtl/core/cam_checker.sv
tb/sv/cross_arm_mask_filter_test.sv
